// ===== src/rlpg_pkg.sv =====
`default_nettype none

package rlpg_pkg;

	// Shared serial arithmetic widths. The dividend width covers the
	// largest sine depth that the block supports.
	localparam int NUM_W     = 28;
	localparam int DEN_W     = 16;
	localparam int MUL_W     = 17;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int REG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam logic [REG_IDX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RED     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_GREEN   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_BLUE    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PARAM_A = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_PARAM_B = 3'd5;

	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;

	localparam logic [15:0] DEF_PERIOD_MS = 16'd2000;
	localparam logic [15:0] DEF_MIN_PCT   = 16'd20;
	localparam logic [15:0] DEF_FREQ_HZ   = 16'd2;
	localparam logic [15:0] DEF_DUTY_PCT  = 16'd50;
	localparam logic [15:0] PCT_FULL      = 16'd100;
	localparam int          MS_PER_S      = 1000;

	localparam logic [16:0] ONE_Q16  = 17'h10000;
	localparam logic [16:0] HALF_Q16 = 17'h08000;

	typedef enum logic [1:0] {
		MODE_OFF,
		MODE_STATIC,
		MODE_BREATH,
		MODE_BLINK
	} mode_t;

	typedef enum logic [1:0] {
		TX_OK,
		TX_REJECTED,
		TX_TIMEOUT,
		TX_ERROR
	} tx_status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_BR_TOTAL,
		ST_BR_PHASE,
		ST_BR_AMUL,
		ST_BR_ADIV,
		ST_BR_UDIV,
		ST_BR_INTERP,
		ST_BR_MIN,
		ST_BR_SCALE,
		ST_BR_RED,
		ST_BR_GREEN,
		ST_BR_BLUE,
		ST_BL_CYC,
		ST_BL_ONMUL,
		ST_BL_ONDIV,
		ST_BL_PHASE,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic       func;
		logic [1:0] tx_status;
	} item_t;

	typedef struct packed {
		logic [7:0] green_out;
		logic [7:0] red_out;
		logic [7:0] blue_out;
		logic       send;
		logic       reset_channel;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	// Quarter wave of the sine in sixteen segments, full scale 65536.
	// Indices past the end read as full scale.
	function automatic logic [16:0] quarter_sine(input logic [4:0] idx);
		logic [16:0] val;
		case (idx)
			5'd0:    val = 17'd0;
			5'd1:    val = 17'd6424;
			5'd2:    val = 17'd12785;
			5'd3:    val = 17'd19024;
			5'd4:    val = 17'd25080;
			5'd5:    val = 17'd30893;
			5'd6:    val = 17'd36410;
			5'd7:    val = 17'd41576;
			5'd8:    val = 17'd46341;
			5'd9:    val = 17'd50660;
			5'd10:   val = 17'd54491;
			5'd11:   val = 17'd57798;
			5'd12:   val = 17'd60547;
			5'd13:   val = 17'd62714;
			5'd14:   val = 17'd64277;
			5'd15:   val = 17'd65220;
			default: val = 17'd65536;
		endcase
		return val;
	endfunction

endpackage

`default_nettype wire

// ===== src/rgb_led_pattern_generator.sv =====
`default_nettype none

// RGB LED pattern generator. Each tick item yields one GRB pixel from the
// configured mode (off, static colour, sine breathing or blink) together with
// a send request when the pixel changes, or always in off mode; report items
// count consecutive transmit timeouts and, at the recovery limit, request a
// channel reset with a black pixel. Reports and ticks in off or static mode
// go from the dispatch state straight to the commit state. Breathing and
// blink ticks run through one bit-serial divider (28 steps; five divisions
// for breathing and three for blink) and one bit-serial multiplier (17
// steps; six products for breathing and one for blink). Items are taken one
// at a time; the result register lets the next item be taken while a result
// is still waiting to be collected. The user must write the configuration
// only while the block is idle; the block itself does not enforce this. A
// write of the mode register restarts the phase.
module rgb_led_pattern_generator #(
	parameter int TICK_MS        = 50,
	parameter int RECOVERY_LIMIT = 3,
	parameter int SINE_DEPTH     = 256
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  wire rlpg_pkg::item_t                  item,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output rlpg_pkg::result_t                     result,
	input  wire logic                             cfg_we,
	input  wire logic [rlpg_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [rlpg_pkg::CFG_W-1:0]       cfg_data
);

	localparam int MAX_PERIOD = 65535 / TICK_MS;
	localparam int PH_W       = $clog2(MAX_PERIOD);
	localparam int DEP_W      = $clog2(SINE_DEPTH);
	localparam int CYC_BASE   = rlpg_pkg::MS_PER_S / TICK_MS;

	rlpg_pkg::state_t   state_q, state_d;
	rlpg_pkg::div_req_t div_req;
	rlpg_pkg::div_rsp_t div_rsp;
	rlpg_pkg::mul_req_t mul_req;
	rlpg_pkg::mul_rsp_t mul_rsp;

	// Configuration and architectural state.
	rlpg_pkg::mode_t mode_q;
	logic [7:0]      red_q, green_q, blue_q;
	logic [15:0]     param_a_q, param_b_q;
	logic [PH_W-1:0] phase_q;
	logic [7:0]      pix_g_q, pix_r_q, pix_b_q;
	logic [1:0]      tmo_q;
	logic            issued_q;
	logic            result_valid_q;

	// Per-item working registers.
	rlpg_pkg::item_t            item_q;
	rlpg_pkg::result_t          result_q;
	logic [rlpg_pkg::DEN_W-1:0] per_q;
	logic [rlpg_pkg::NUM_W-1:0] num_q;
	logic [rlpg_pkg::NUM_W-1:0] on_q;
	logic [DEP_W-1:0]           a_q;
	logic                       neg_q;
	logic [4:0]                 i_q;
	logic [9:0]                 f_q;
	logic [16:0]                h_q, m_q, bright_q;
	logic [7:0]                 new_g_q, new_r_q, new_b_q;
	logic                       send_force_q;
	logic                       rst_q;

	// Datapath terms.
	logic [15:0]     period, pct_raw, freq, duty;
	logic [6:0]      min_pct;
	logic [PH_W:0]   phase_inc;
	logic [15:0]     quo16, per_new;
	logic [15:0]     u_val;
	logic [14:0]     w_val, wm_val;
	logic [16:0]     sine_lo, sine_hi, sine_diff, s_val, h_val;
	logic [17:0]     bright_sum;
	logic [1:0]      tmo_next;
	logic            recover;
	logic            unit_done;
	logic            slot_free;
	logic            commit;
	logic            changed;
	logic            lit;

	rlpg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	rlpg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_comb begin
		period    = (param_a_q == 16'd0) ? rlpg_pkg::DEF_PERIOD_MS : param_a_q;
		pct_raw   = (param_b_q == 16'd0) ? rlpg_pkg::DEF_MIN_PCT : param_b_q;
		min_pct   = (pct_raw > rlpg_pkg::PCT_FULL) ? 7'd100 : pct_raw[6:0];
		freq      = (param_a_q == 16'd0) ? rlpg_pkg::DEF_FREQ_HZ : param_a_q;
		duty      = (param_b_q == 16'd0) ? rlpg_pkg::DEF_DUTY_PCT : param_b_q;
		phase_inc = {1'b0, phase_q} + (PH_W + 1)'(1);

		quo16   = div_rsp.quo[15:0];
		per_new = (quo16 == 16'd0) ? 16'd1 : quo16;

		// Fold the turn fraction onto the first quadrant.
		u_val  = div_rsp.quo[15:0];
		w_val  = {1'b0, u_val[13:0]};
		wm_val = u_val[14] ? (15'd16384 - w_val) : w_val;

		sine_lo   = rlpg_pkg::quarter_sine(i_q);
		sine_hi   = rlpg_pkg::quarter_sine(i_q + 5'd1);
		sine_diff = sine_hi - sine_lo;
		s_val     = sine_lo + mul_rsp.prod[26:10];
		h_val     = neg_q ? (rlpg_pkg::HALF_Q16 - {1'b0, s_val[16:1]})
		                  : (rlpg_pkg::HALF_Q16 + {1'b0, s_val[16:1]});

		bright_sum = {1'b0, m_q} + {1'b0, mul_rsp.prod[32:16]};

		tmo_next = tmo_q + 2'd1;
		recover  = (item_q.func == rlpg_pkg::FUNC_REPORT)
		        && (item_q.tx_status == rlpg_pkg::TX_TIMEOUT)
		        && (tmo_next >= 2'(RECOVERY_LIMIT));

		lit       = rlpg_pkg::NUM_W'(div_rsp.rem) < on_q;
		unit_done = div_rsp.done | mul_rsp.done;
		slot_free = !result_valid_q || !result_stall;
		commit    = (state_q == rlpg_pkg::ST_COMMIT) && slot_free;
		changed   = (new_g_q != pix_g_q) || (new_r_q != pix_r_q) || (new_b_q != pix_b_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rlpg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		div_req      = '0;
		mul_req      = '0;
		item_stall   = (state_q != rlpg_pkg::ST_IDLE);
		case (state_q)
			rlpg_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = rlpg_pkg::ST_DISPATCH;
				end
			end
			rlpg_pkg::ST_DISPATCH: begin
				if (item_q.func == rlpg_pkg::FUNC_REPORT) begin
					state_d = rlpg_pkg::ST_COMMIT;
				end else begin
					case (mode_q)
						rlpg_pkg::MODE_BREATH: state_d = rlpg_pkg::ST_BR_TOTAL;
						rlpg_pkg::MODE_BLINK:  state_d = rlpg_pkg::ST_BL_CYC;
						default:               state_d = rlpg_pkg::ST_COMMIT;
					endcase
				end
			end
			rlpg_pkg::ST_BR_TOTAL: begin
				div_req.start = !issued_q;
				div_req.num   = rlpg_pkg::NUM_W'(period);
				div_req.den   = rlpg_pkg::DEN_W'(TICK_MS);
				if (div_rsp.done) state_d = rlpg_pkg::ST_BR_PHASE;
			end
			rlpg_pkg::ST_BR_PHASE: begin
				div_req.start = !issued_q;
				div_req.num   = rlpg_pkg::NUM_W'(phase_inc);
				div_req.den   = per_q;
				if (div_rsp.done) state_d = rlpg_pkg::ST_BR_AMUL;
			end
			rlpg_pkg::ST_BR_AMUL: begin
				mul_req.start = !issued_q;
				mul_req.a     = rlpg_pkg::MUL_W'(phase_q);
				mul_req.b     = rlpg_pkg::MUL_W'(SINE_DEPTH);
				if (mul_rsp.done) state_d = rlpg_pkg::ST_BR_ADIV;
			end
			rlpg_pkg::ST_BR_ADIV: begin
				div_req.start = !issued_q;
				div_req.num   = num_q;
				div_req.den   = per_q;
				if (div_rsp.done) state_d = rlpg_pkg::ST_BR_UDIV;
			end
			rlpg_pkg::ST_BR_UDIV: begin
				div_req.start = !issued_q;
				div_req.num   = rlpg_pkg::NUM_W'({a_q, 16'h0000});
				div_req.den   = rlpg_pkg::DEN_W'(SINE_DEPTH);
				if (div_rsp.done) state_d = rlpg_pkg::ST_BR_INTERP;
			end
			rlpg_pkg::ST_BR_INTERP: begin
				mul_req.start = !issued_q;
				mul_req.a     = sine_diff;
				mul_req.b     = rlpg_pkg::MUL_W'(f_q);
				if (mul_rsp.done) state_d = rlpg_pkg::ST_BR_MIN;
			end
			rlpg_pkg::ST_BR_MIN: begin
				div_req.start = !issued_q;
				div_req.num   = rlpg_pkg::NUM_W'({min_pct, 16'h0000});
				div_req.den   = rlpg_pkg::PCT_FULL;
				if (div_rsp.done) state_d = rlpg_pkg::ST_BR_SCALE;
			end
			rlpg_pkg::ST_BR_SCALE: begin
				mul_req.start = !issued_q;
				mul_req.a     = h_q;
				mul_req.b     = rlpg_pkg::ONE_Q16 - m_q;
				if (mul_rsp.done) state_d = rlpg_pkg::ST_BR_RED;
			end
			rlpg_pkg::ST_BR_RED: begin
				mul_req.start = !issued_q;
				mul_req.a     = rlpg_pkg::MUL_W'(red_q);
				mul_req.b     = bright_q;
				if (mul_rsp.done) state_d = rlpg_pkg::ST_BR_GREEN;
			end
			rlpg_pkg::ST_BR_GREEN: begin
				mul_req.start = !issued_q;
				mul_req.a     = rlpg_pkg::MUL_W'(green_q);
				mul_req.b     = bright_q;
				if (mul_rsp.done) state_d = rlpg_pkg::ST_BR_BLUE;
			end
			rlpg_pkg::ST_BR_BLUE: begin
				mul_req.start = !issued_q;
				mul_req.a     = rlpg_pkg::MUL_W'(blue_q);
				mul_req.b     = bright_q;
				if (mul_rsp.done) state_d = rlpg_pkg::ST_COMMIT;
			end
			rlpg_pkg::ST_BL_CYC: begin
				div_req.start = !issued_q;
				div_req.num   = rlpg_pkg::NUM_W'(CYC_BASE);
				div_req.den   = freq;
				if (div_rsp.done) state_d = rlpg_pkg::ST_BL_ONMUL;
			end
			rlpg_pkg::ST_BL_ONMUL: begin
				mul_req.start = !issued_q;
				mul_req.a     = rlpg_pkg::MUL_W'(per_q);
				mul_req.b     = rlpg_pkg::MUL_W'(duty);
				if (mul_rsp.done) state_d = rlpg_pkg::ST_BL_ONDIV;
			end
			rlpg_pkg::ST_BL_ONDIV: begin
				div_req.start = !issued_q;
				div_req.num   = num_q;
				div_req.den   = rlpg_pkg::PCT_FULL;
				if (div_rsp.done) state_d = rlpg_pkg::ST_BL_PHASE;
			end
			rlpg_pkg::ST_BL_PHASE: begin
				div_req.start = !issued_q;
				div_req.num   = rlpg_pkg::NUM_W'(phase_inc);
				div_req.den   = per_q;
				if (div_rsp.done) state_d = rlpg_pkg::ST_COMMIT;
			end
			rlpg_pkg::ST_COMMIT: begin
				if (slot_free) state_d = rlpg_pkg::ST_IDLE;
			end
			default: begin
				state_d = rlpg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q       <= 1'b0;
			result_valid_q <= 1'b0;
			mode_q         <= rlpg_pkg::MODE_OFF;
			red_q          <= '0;
			green_q        <= '0;
			blue_q         <= '0;
			param_a_q      <= '0;
			param_b_q      <= '0;
			phase_q        <= '0;
			pix_g_q        <= '0;
			pix_r_q        <= '0;
			pix_b_q        <= '0;
			tmo_q          <= '0;
		end else begin
			issued_q <= (issued_q | div_req.start | mul_req.start) & ~unit_done;

			if (commit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			if (state_q == rlpg_pkg::ST_DISPATCH) begin
				if (item_q.func == rlpg_pkg::FUNC_REPORT) begin
					if (item_q.tx_status == rlpg_pkg::TX_OK) begin
						tmo_q <= '0;
					end else if (item_q.tx_status == rlpg_pkg::TX_TIMEOUT) begin
						tmo_q <= recover ? 2'd0 : tmo_next;
					end
				end else if (mode_q == rlpg_pkg::MODE_STATIC) begin
					phase_q <= '0;
				end
			end

			if ((state_q == rlpg_pkg::ST_BR_PHASE || state_q == rlpg_pkg::ST_BL_PHASE)
			    && div_rsp.done) begin
				phase_q <= div_rsp.rem[PH_W-1:0];
			end

			if (commit) begin
				pix_g_q <= new_g_q;
				pix_r_q <= new_r_q;
				pix_b_q <= new_b_q;
			end

			if (cfg_we) begin
				case (cfg_index)
					rlpg_pkg::REG_MODE: begin
						mode_q  <= rlpg_pkg::mode_t'(cfg_data[1:0]);
						phase_q <= '0;
					end
					rlpg_pkg::REG_RED:     red_q     <= cfg_data[7:0];
					rlpg_pkg::REG_GREEN:   green_q   <= cfg_data[7:0];
					rlpg_pkg::REG_BLUE:    blue_q    <= cfg_data[7:0];
					rlpg_pkg::REG_PARAM_A: param_a_q <= cfg_data;
					rlpg_pkg::REG_PARAM_B: param_b_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_q <= item;
		end

		case (state_q)
			rlpg_pkg::ST_DISPATCH: begin
				send_force_q <= 1'b0;
				rst_q        <= 1'b0;
				new_g_q      <= pix_g_q;
				new_r_q      <= pix_r_q;
				new_b_q      <= pix_b_q;
				if (item_q.func == rlpg_pkg::FUNC_REPORT) begin
					if (recover) begin
						send_force_q <= 1'b1;
						rst_q        <= 1'b1;
						new_g_q      <= '0;
						new_r_q      <= '0;
						new_b_q      <= '0;
					end
				end else if (mode_q == rlpg_pkg::MODE_OFF) begin
					send_force_q <= 1'b1;
					new_g_q      <= '0;
					new_r_q      <= '0;
					new_b_q      <= '0;
				end else if (mode_q == rlpg_pkg::MODE_STATIC) begin
					new_g_q <= green_q;
					new_r_q <= red_q;
					new_b_q <= blue_q;
				end
			end
			rlpg_pkg::ST_BR_TOTAL, rlpg_pkg::ST_BL_CYC: begin
				if (div_rsp.done) per_q <= per_new;
			end
			rlpg_pkg::ST_BR_AMUL, rlpg_pkg::ST_BL_ONMUL: begin
				if (mul_rsp.done) num_q <= mul_rsp.prod[rlpg_pkg::NUM_W-1:0];
			end
			rlpg_pkg::ST_BR_ADIV: begin
				if (div_rsp.done) a_q <= div_rsp.quo[DEP_W-1:0];
			end
			rlpg_pkg::ST_BR_UDIV: begin
				if (div_rsp.done) begin
					neg_q <= u_val[15];
					i_q   <= wm_val[14:10];
					f_q   <= wm_val[9:0];
				end
			end
			rlpg_pkg::ST_BR_INTERP: begin
				if (mul_rsp.done) h_q <= h_val;
			end
			rlpg_pkg::ST_BR_MIN: begin
				if (div_rsp.done) m_q <= div_rsp.quo[16:0];
			end
			rlpg_pkg::ST_BR_SCALE: begin
				if (mul_rsp.done) bright_q <= bright_sum[16:0];
			end
			rlpg_pkg::ST_BR_RED: begin
				if (mul_rsp.done) new_r_q <= mul_rsp.prod[23:16];
			end
			rlpg_pkg::ST_BR_GREEN: begin
				if (mul_rsp.done) new_g_q <= mul_rsp.prod[23:16];
			end
			rlpg_pkg::ST_BR_BLUE: begin
				if (mul_rsp.done) new_b_q <= mul_rsp.prod[23:16];
			end
			rlpg_pkg::ST_BL_ONDIV: begin
				if (div_rsp.done) on_q <= div_rsp.quo;
			end
			rlpg_pkg::ST_BL_PHASE: begin
				if (div_rsp.done) begin
					new_g_q <= lit ? green_q : 8'd0;
					new_r_q <= lit ? red_q : 8'd0;
					new_b_q <= lit ? blue_q : 8'd0;
				end
			end
			default: begin
			end
		endcase

		if (commit) begin
			result_q.green_out     <= new_g_q;
			result_q.red_out       <= new_r_q;
			result_q.blue_out      <= new_b_q;
			result_q.send          <= send_force_q | changed;
			result_q.reset_channel <= rst_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_rsp.done && mul_rsp.done))
		else $error("divider and multiplier finished in the same cycle");

	a_commit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> result_valid_q)
		else $error("committed item did not reach the result register");

	a_recovery_black: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.reset_channel) |->
		(result_q.send && result_q.green_out == 8'd0 && result_q.red_out == 8'd0
		 && result_q.blue_out == 8'd0))
		else $error("channel reset without a black refresh");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == rlpg_pkg::ST_BR_PHASE || state_q == rlpg_pkg::ST_BL_PHASE)
		 && div_rsp.done) |=> (rlpg_pkg::DEN_W'(phase_q) < per_q))
		else $error("phase left outside its period");

	a_timeout_run: assert property (@(posedge clk) disable iff (!arst_n)
		tmo_q < 2'(RECOVERY_LIMIT))
		else $error("timeout run reached the recovery limit");

endmodule

`default_nettype wire

// ===== src/rlpg_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, dividend MSB first.
module rlpg_div (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rlpg_pkg::div_req_t  req,
	output rlpg_pkg::div_rsp_t       rsp
);

	localparam int CNT_W = $clog2(rlpg_pkg::NUM_W);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [rlpg_pkg::NUM_W-1:0]   quo_q;
	logic [rlpg_pkg::DEN_W-1:0]   rem_q;
	logic [rlpg_pkg::DEN_W-1:0]   den_q;
	logic [rlpg_pkg::DEN_W:0]     trial;
	logic [rlpg_pkg::DEN_W:0]     diff;
	logic                         fits;

	always_comb begin
		trial = {rem_q, quo_q[rlpg_pkg::NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(rlpg_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[rlpg_pkg::NUM_W-2:0], fits};
			// The partial remainder always stays below a nonzero divisor.
			rem_q <= fits ? diff[rlpg_pkg::DEN_W-1:0] : trial[rlpg_pkg::DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// ===== src/rlpg_mul.sv =====
`default_nettype none

// Shift-and-add multiplier, one multiplier bit per cycle, LSB first.
module rlpg_mul (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rlpg_pkg::mul_req_t  req,
	output rlpg_pkg::mul_rsp_t       rsp
);

	localparam int CNT_W = $clog2(rlpg_pkg::MUL_W);

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [rlpg_pkg::PROD_W-1:0]   a_sh_q;
	logic [rlpg_pkg::MUL_W-1:0]    b_q;
	logic [rlpg_pkg::PROD_W-1:0]   acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(rlpg_pkg::MUL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_sh_q <= rlpg_pkg::PROD_W'(req.a);
			b_q    <= req.b;
			acc_q  <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_sh_q;
			end
			a_sh_q <= a_sh_q << 1;
			b_q    <= b_q >> 1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

`default_nettype wire
